### sv/alarm_blink_pattern_monitor_top_assert.svh
// Assertion macros for the alarm blink pattern monitor.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef ALARM_BLINK_PATTERN_MONITOR_TOP_ASSERT_SVH
`define ALARM_BLINK_PATTERN_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define ABPM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABPM_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/abpm_pkg.sv
// Shared types and constants for the alarm blink pattern monitor.
// No dependencies.
package abpm_pkg;

    localparam int CH_IN_W    = 3;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_EXPECTED_WIDTH  = 3'd1,
        REG_WIDTH_TOLERANCE = 3'd2,
        REG_WINDOW          = 3'd3,
        REG_CONTINUOUS      = 3'd4,
        REG_OVERCURRENT     = 3'd5,
        REG_OVERVOLTAGE     = 3'd6,
        REG_POSITION_ERROR  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_OVERCURRENT = 2'd0,
        CLS_OVERVOLTAGE = 2'd1,
        CLS_POSITION    = 2'd2,
        CLS_UNKNOWN     = 2'd3
    } pattern_class_t;

    typedef struct packed {
        logic [15:0]        sample_interval;
        logic [15:0]        expected_width;
        logic [15:0]        width_tolerance;
        logic [19:0]        window;
        logic [19:0]        continuous;
        logic [COUNT_W-1:0] overcurrent;
        logic [COUNT_W-1:0] overvoltage;
        logic [COUNT_W-1:0] position_error;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  last_sample;
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  pulse_start;
        logic               prev_level;
        logic               pulse_active;
        logic [COUNT_W-1:0] count;
        logic               critical;
    } chan_t;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel;
        logic               level;
        logic [TIME_W-1:0]  now;
    } sample_t;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel_out;
        logic               accepted;
        logic               pulse_counted;
        logic [TIME_W-1:0]  pulse_width;
        logic               window_closed;
        pattern_class_t     pattern_class;
        logic [COUNT_W-1:0] pattern_count;
        logic               channel_critical;
    } result_t;

endpackage

### sv/abpm_cfg_regs.sv
// Configuration register bank of the alarm blink pattern monitor.
// Depends on abpm_pkg.
module abpm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abpm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [abpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output abpm_pkg::cfg_t                   cfg
);

    abpm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= 16'd10;
            cfg_reg.expected_width  <= 16'd200;
            cfg_reg.width_tolerance <= 16'd50;
            cfg_reg.window          <= 20'd5000;
            cfg_reg.continuous      <= 20'd10000;
            cfg_reg.overcurrent     <= 8'd2;
            cfg_reg.overvoltage     <= 8'd3;
            cfg_reg.position_error  <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                abpm_pkg::REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_wdata[15:0];
                abpm_pkg::REG_EXPECTED_WIDTH:  cfg_reg.expected_width  <= cfg_wdata[15:0];
                abpm_pkg::REG_WIDTH_TOLERANCE: cfg_reg.width_tolerance <= cfg_wdata[15:0];
                abpm_pkg::REG_WINDOW:          cfg_reg.window          <= cfg_wdata[19:0];
                abpm_pkg::REG_CONTINUOUS:      cfg_reg.continuous      <= cfg_wdata[19:0];
                abpm_pkg::REG_OVERCURRENT:     cfg_reg.overcurrent     <= cfg_wdata[7:0];
                abpm_pkg::REG_OVERVOLTAGE:     cfg_reg.overvoltage     <= cfg_wdata[7:0];
                abpm_pkg::REG_POSITION_ERROR:  cfg_reg.position_error  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/abpm_chan_state.sv
// Per-channel state registers with read select and critical flag summary.
// Depends on abpm_pkg.
module abpm_chan_state #(
    parameter int CHANNELS = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [abpm_pkg::CH_IN_W-1:0]  channel,
    input  logic                          wr_en,
    input  abpm_pkg::chan_t               st_next,
    output abpm_pkg::chan_t               rd_state,
    output logic                          any_next
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    abpm_pkg::chan_t   st_reg [CHANNELS];
    logic [31:0]       ch_ext;
    logic [IDX_W-1:0]  idx;
    logic              in_range;

    assign ch_ext   = 32'(channel);
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = ch_ext < 32'(CHANNELS);

    assign rd_state = in_range ? st_reg[idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (wr_en && in_range)
        begin
            st_reg[idx] <= st_next;
        end
    end

    // flags as they stand after this item's write
    always_comb
    begin
        any_next = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (wr_en && in_range && (idx == IDX_W'(i)))
            begin
                any_next = any_next | st_next.critical;
            end
            else
            begin
                any_next = any_next | st_reg[i].critical;
            end
        end
    end

endmodule

### sv/abpm_step_logic.sv
// Single-item step: rate limit, edge and pulse width check, window classification.
// Depends on abpm_pkg.
module abpm_step_logic #(
    parameter int CHANNELS = 5
) (
    input  abpm_pkg::sample_t  smp,
    input  abpm_pkg::cfg_t     cfg,
    input  abpm_pkg::chan_t    cur,
    output logic               wr_en,
    output abpm_pkg::chan_t    nxt,
    output abpm_pkg::result_t  res
);

    logic                            in_range;
    logic                            acc;
    logic [abpm_pkg::TIME_W-1:0]     since_last;
    logic [abpm_pkg::TIME_W-1:0]     width;
    logic [abpm_pkg::TIME_W-1:0]     win_age;
    logic [15:0]                     lo;
    logic [16:0]                     hi;
    logic                            width_ok;
    logic                            falling;
    logic                            counted;
    logic [abpm_pkg::COUNT_W-1:0]    cnt_mid;
    logic                            closed;
    logic                            cont;

    assign in_range   = 32'(smp.channel) < 32'(CHANNELS);
    assign since_last = smp.now - cur.last_sample;
    assign acc        = in_range && (since_last >= 32'(cfg.sample_interval));

    assign width    = smp.now - cur.pulse_start;
    assign lo       = (cfg.expected_width > cfg.width_tolerance)
                    ? (cfg.expected_width - cfg.width_tolerance) : 16'd0;
    assign hi       = 17'(cfg.expected_width) + 17'(cfg.width_tolerance);
    assign width_ok = (width >= 32'(lo)) && (width <= 32'(hi));

    assign falling  = (cur.prev_level != smp.level) && !smp.level && cur.pulse_active;
    assign counted  = falling && width_ok;
    assign cnt_mid  = (counted && (cur.count != abpm_pkg::COUNT_MAX))
                    ? cur.count + 8'd1 : cur.count;

    assign win_age  = smp.now - cur.window_start;
    assign closed   = win_age >= 32'(cfg.window);
    // a closed window leaves the count at zero, so the !closed term keeps this from firing then
    assign cont     = !closed && (cnt_mid != '0) && (win_age >= 32'(cfg.continuous));

    assign wr_en = acc;

    always_comb
    begin
        nxt             = cur;
        res             = '0;
        res.channel_out = smp.channel;
        if (acc)
        begin
            res.accepted    = 1'b1;
            nxt.last_sample = smp.now;
            nxt.prev_level  = smp.level;
            nxt.count       = cnt_mid;
            if ((cur.prev_level != smp.level) && smp.level)
            begin
                nxt.pulse_start  = smp.now;
                nxt.pulse_active = 1'b1;
            end
            if (falling)
            begin
                nxt.pulse_active  = 1'b0;
                res.pulse_width   = width;
                res.pulse_counted = counted;
            end
            if (closed)
            begin
                if (cnt_mid != '0)
                begin
                    res.window_closed = 1'b1;
                    res.pattern_count = cnt_mid;
                    if (cnt_mid == cfg.overcurrent)
                    begin
                        res.pattern_class = abpm_pkg::CLS_OVERCURRENT;
                        nxt.critical      = 1'b1;
                    end
                    else if (cnt_mid == cfg.overvoltage)
                    begin
                        res.pattern_class = abpm_pkg::CLS_OVERVOLTAGE;
                        nxt.critical      = 1'b1;
                    end
                    else if (cnt_mid == cfg.position_error)
                    begin
                        res.pattern_class = abpm_pkg::CLS_POSITION;
                    end
                    else
                    begin
                        res.pattern_class = abpm_pkg::CLS_UNKNOWN;
                    end
                end
                nxt.count        = '0;
                nxt.window_start = smp.now;
            end
            if (cont)
            begin
                nxt.critical = 1'b1;
            end
        end
        res.channel_critical = in_range ? nxt.critical : 1'b0;
    end

endmodule

### sv/alarm_blink_pattern_monitor_top.sv
// Top level of the alarm blink pattern monitor: input register, step, result register.
// Depends on abpm_pkg, abpm_cfg_regs, abpm_chan_state, abpm_step_logic and the assert header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one alarm line sample per item:
//   channel, level and a millisecond timestamp now_ms. Output channel
//   (out_valid/out_ready) returns exactly one result item per input item, in order.
//   Items enter an input register, the per-channel step runs combinationally from
//   there into the result register, and one item per cycle is sustained while
//   out_ready stays high. Per-channel state is updated at the edge the result
//   is loaded, so consecutive items on one channel see each other's effects
//   without stall.
//   When out_ready is low the result register holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr at the clock edge;
//   the user must write only while no item is in flight, which the block does not enforce.
//   Reset (rst_n low, asynchronous) empties both registers, clears all channel
//   state and critical flags, and loads the configuration defaults.
`include "alarm_blink_pattern_monitor_top_assert.svh"

module alarm_blink_pattern_monitor_top #(
    parameter int CHANNELS = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abpm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [abpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [abpm_pkg::CH_IN_W-1:0]     channel,
    input  logic                             level,
    input  logic [abpm_pkg::TIME_W-1:0]      now_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [abpm_pkg::CH_IN_W-1:0]     channel_out,
    output logic                             accepted,
    output logic                             pulse_counted,
    output logic [abpm_pkg::TIME_W-1:0]      pulse_width_ms,
    output logic                             window_closed,
    output logic [1:0]                       pattern_class,
    output logic [abpm_pkg::COUNT_W-1:0]     pattern_count,
    output logic                             channel_critical,
    output logic                             any_critical
);

    abpm_pkg::cfg_t     cfg;
    abpm_pkg::sample_t  in_reg;
    logic               in_valid_reg;
    abpm_pkg::result_t  out_reg;
    logic               out_any_reg;
    logic               out_valid_reg;
    logic               advance;
    abpm_pkg::chan_t    cur_state;
    abpm_pkg::chan_t    st_next;
    logic               wr_en;
    abpm_pkg::result_t  res_next;
    logic               any_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    abpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    abpm_chan_state #(.CHANNELS(CHANNELS)) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .channel  (in_reg.channel),
        .wr_en    (wr_en && advance),
        .st_next  (st_next),
        .rd_state (cur_state),
        .any_next (any_next)
    );

    abpm_step_logic #(.CHANNELS(CHANNELS)) u_step (
        .smp   (in_reg),
        .cfg   (cfg),
        .cur   (cur_state),
        .wr_en (wr_en),
        .nxt   (st_next),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg.channel <= channel;
            in_reg.level   <= level;
            in_reg.now     <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg     <= res_next;
            out_any_reg <= any_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign channel_out      = out_reg.channel_out;
    assign accepted         = out_reg.accepted;
    assign pulse_counted    = out_reg.pulse_counted;
    assign pulse_width_ms   = out_reg.pulse_width;
    assign window_closed    = out_reg.window_closed;
    assign pattern_class    = out_reg.pattern_class;
    assign pattern_count    = out_reg.pattern_count;
    assign channel_critical = out_reg.channel_critical;
    assign any_critical     = out_any_reg;

    `ABPM_IMPLY(a_acc, out_valid && (pulse_counted || window_closed), accepted, "work on reject")
    `ABPM_IMPLY(a_closed_nz, out_valid && window_closed, pattern_count != '0, "zero count")
    `ABPM_IMPLY(a_crit_in_any, out_valid && channel_critical, any_critical, "critical not in any")
    `ABPM_NEXT(a_advance_loads, advance, out_valid_reg, "result register not loaded")

endmodule

### sim/tb_alarm_blink_pattern_monitor_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for alarm_blink_pattern_monitor_top: directed sample table, then
// random alarm line streams under several register settings, checked by an in-bench predictor.
// Depends on abpm_pkg and the monitor RTL.
module tb_alarm_blink_pattern_monitor_top;
    import abpm_pkg::*;

    localparam int CHANNELS = 5;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel_out;
        logic               accepted;
        logic               pulse_counted;
        logic [TIME_W-1:0]  pulse_width;
        logic               window_closed;
        pattern_class_t     pattern_class;
        logic [COUNT_W-1:0] pattern_count;
        logic               channel_critical;
        logic               any_critical;
    } alarm_result_t;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel;
        logic               level;
        logic [TIME_W-1:0]  now;
        logic               typed;
        alarm_result_t      want;
    } sample_row_t;

    localparam cfg_t CFG_DEFAULT = '{16'd10, 16'd200, 16'd50, 20'd5000, 20'd10000,
                                     8'd2, 8'd3, 8'd4};

    // rows with typed = 0 are checked against the predictor
    localparam sample_row_t DIRECTED [22] = '{
        '{3'd5, 1'b1, 32'd0, 1'b1,
          '{3'd5, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd7, 1'b0, 32'hFFFF_FFFF, 1'b1,
          '{3'd7, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b0, 32'd5, 1'b1,
          '{3'd0, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b1, 32'd100, 1'b1,
          '{3'd0, 1'b1, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b0, 32'd300, 1'b1,
          '{3'd0, 1'b1, 1'b1, 32'd200, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b1, 32'd305, 1'b1,
          '{3'd0, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b1, 32'd400, 1'b1,
          '{3'd0, 1'b1, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b0, 32'd650, 1'b1,
          '{3'd0, 1'b1, 1'b1, 32'd250, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd1, 1'b1, 32'd20, 1'b0, '0},
        '{3'd1, 1'b0, 32'd271, 1'b1,
          '{3'd1, 1'b1, 1'b0, 32'd251, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd1, 1'b1, 32'd300, 1'b0, '0},
        '{3'd1, 1'b0, 32'd450, 1'b1,
          '{3'd1, 1'b1, 1'b1, 32'd150, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b0}},
        '{3'd0, 1'b0, 32'd5000, 1'b1,
          '{3'd0, 1'b1, 1'b0, 32'd0, 1'b1, CLS_OVERCURRENT, 8'd2, 1'b1, 1'b1}},
        '{3'd1, 1'b0, 32'd11000, 1'b1,
          '{3'd1, 1'b1, 1'b0, 32'd0, 1'b1, CLS_UNKNOWN, 8'd1, 1'b0, 1'b1}},
        '{3'd2, 1'b1, 32'hFFFF_FFF0, 1'b1,
          '{3'd2, 1'b1, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b1}},
        '{3'd2, 1'b0, 32'h0000_00B8, 1'b1,
          '{3'd2, 1'b1, 1'b1, 32'd200, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b1}},
        '{3'd2, 1'b1, 32'h0000_00BD, 1'b1,
          '{3'd2, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b1}},
        '{3'd0, 1'b1, 32'd5005, 1'b1,
          '{3'd0, 1'b0, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b1, 1'b1}},
        '{3'd3, 1'b1, 32'h7FFF_FFFF, 1'b0, '0},
        '{3'd4, 1'b1, 32'd10, 1'b1,
          '{3'd4, 1'b1, 1'b0, 32'd0, 1'b0, CLS_OVERCURRENT, 8'd0, 1'b0, 1'b1}},
        '{3'd4, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{3'd6, 1'b1, 32'h1234_5678, 1'b0, '0}
    };

    localparam cfg_t PHASE_CFG [5] = '{
        '{16'd2, 16'd20, 16'd5, 20'd200, 20'd100, 8'd2, 8'd3, 8'd4},
        '{16'd0, 16'd0, 16'd0, 20'd0, 20'd1, 8'd0, 8'd0, 8'd0},
        '{16'd65535, 16'd65535, 16'd65535, 20'd1000000, 20'd1000000,
          8'd255, 8'd255, 8'd255},
        '{16'd1, 16'd15, 16'd4, 20'd120, 20'd1000000, 8'd2, 8'd2, 8'd2},
        '{16'd5, 16'd40, 16'd10, 20'd400, 20'd150, 8'd200, 8'd3, 8'd3}
    };
    localparam int PHASE_ITEMS [5] = '{180, 90, 70, 120, 120};

    // count saturation: long window, every pulse within tolerance
    localparam cfg_t SATURATE_CFG = '{16'd0, 16'd10, 16'd10, 20'd1000000, 20'd1000000,
                                      8'd255, 8'd1, 8'd2};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CH_IN_W-1:0]    channel = '0;
    logic                  level = 1'b0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CH_IN_W-1:0]    channel_out;
    logic                  accepted;
    logic                  pulse_counted;
    logic [TIME_W-1:0]     pulse_width_ms;
    logic                  window_closed;
    logic [1:0]            pattern_class;
    logic [COUNT_W-1:0]    pattern_count;
    logic                  channel_critical;
    logic                  any_critical;

    cfg_t          cfg_q;
    chan_t         line_state [CHANNELS];
    alarm_result_t expected_results [$];
    int            mismatches = 0;
    int            calm_left = 0;
    bit            hold_off = 1'b0;

    alarm_blink_pattern_monitor_top #(.CHANNELS(CHANNELS)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .channel          (channel),
        .level            (level),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .channel_out      (channel_out),
        .accepted         (accepted),
        .pulse_counted    (pulse_counted),
        .pulse_width_ms   (pulse_width_ms),
        .window_closed    (window_closed),
        .pattern_class    (pattern_class),
        .pattern_count    (pattern_count),
        .channel_critical (channel_critical),
        .any_critical     (any_critical)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic alarm_result_t predict_alarm(input logic [CH_IN_W-1:0] ch,
                                                    input logic lvl,
                                                    input logic [TIME_W-1:0] t);
        alarm_result_t r;
        chan_t         s;
        logic [31:0]   age;
        logic [31:0]   width;
        logic [32:0]   lo;
        logic [32:0]   hi;
        r = '0;
        r.channel_out = ch;
        if (ch < CHANNELS)
        begin
            s = line_state[ch];
            age = t - s.last_sample;
            if (age < {16'd0, cfg_q.sample_interval})
            begin
                r.channel_critical = s.critical;
            end
            else
            begin
                r.accepted = 1'b1;
                s.last_sample = t;
                if (s.prev_level != lvl)
                begin
                    if (lvl)
                    begin
                        s.pulse_start = t;
                        s.pulse_active = 1'b1;
                    end
                    else if (s.pulse_active)
                    begin
                        width = t - s.pulse_start;
                        lo = (cfg_q.expected_width > cfg_q.width_tolerance)
                             ? {17'd0, cfg_q.expected_width - cfg_q.width_tolerance} : 33'd0;
                        hi = {17'd0, cfg_q.expected_width} + {17'd0, cfg_q.width_tolerance};
                        r.pulse_width = width;
                        if ({1'b0, width} >= lo && {1'b0, width} <= hi)
                        begin
                            r.pulse_counted = 1'b1;
                            if (s.count != COUNT_MAX)
                                s.count = s.count + 8'd1;
                        end
                        s.pulse_active = 1'b0;
                    end
                    s.prev_level = lvl;
                end
                age = t - s.window_start;
                if (age >= {12'd0, cfg_q.window})
                begin
                    if (s.count != 8'd0)
                    begin
                        r.window_closed = 1'b1;
                        r.pattern_count = s.count;
                        if (s.count == cfg_q.overcurrent)
                        begin
                            r.pattern_class = CLS_OVERCURRENT;
                            s.critical = 1'b1;
                        end
                        else if (s.count == cfg_q.overvoltage)
                        begin
                            r.pattern_class = CLS_OVERVOLTAGE;
                            s.critical = 1'b1;
                        end
                        else if (s.count == cfg_q.position_error)
                            r.pattern_class = CLS_POSITION;
                        else
                            r.pattern_class = CLS_UNKNOWN;
                    end
                    s.count = 8'd0;
                    s.window_start = t;
                end
                age = t - s.window_start;
                if (s.count != 8'd0 && age >= {12'd0, cfg_q.continuous})
                    s.critical = 1'b1;
                r.channel_critical = s.critical;
                line_state[ch] = s;
            end
        end
        for (int i = 0; i < CHANNELS; i++)
            if (line_state[i].critical)
                r.any_critical = 1'b1;
        return r;
    endfunction

    task automatic send_sample(input logic [CH_IN_W-1:0] ch, input logic lvl,
                               input logic [TIME_W-1:0] t, input logic typed,
                               input alarm_result_t typed_result);
        alarm_result_t predicted;
        int            gap;
        int            r;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                calm_left = $urandom_range(20, 60);
                gap = 0;
            end
            else if (r < 55)
                gap = 0;
            else if (r < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        level <= lvl;
        now_ms <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_alarm(ch, lvl, t);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_SAMPLE_INTERVAL: cfg_q.sample_interval = val[15:0];
            REG_EXPECTED_WIDTH:  cfg_q.expected_width = val[15:0];
            REG_WIDTH_TOLERANCE: cfg_q.width_tolerance = val[15:0];
            REG_WINDOW:          cfg_q.window = val;
            REG_CONTINUOUS:      cfg_q.continuous = val;
            REG_OVERCURRENT:     cfg_q.overcurrent = val[7:0];
            REG_OVERVOLTAGE:     cfg_q.overvoltage = val[7:0];
            REG_POSITION_ERROR:  cfg_q.position_error = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input cfg_t s);
        wait_drained();
        write_reg(REG_SAMPLE_INTERVAL, {4'd0, s.sample_interval});
        write_reg(REG_EXPECTED_WIDTH, {4'd0, s.expected_width});
        write_reg(REG_WIDTH_TOLERANCE, {4'd0, s.width_tolerance});
        write_reg(REG_WINDOW, s.window);
        write_reg(REG_CONTINUOUS, s.continuous);
        write_reg(REG_OVERCURRENT, {12'd0, s.overcurrent});
        write_reg(REG_OVERVOLTAGE, {12'd0, s.overvoltage});
        write_reg(REG_POSITION_ERROR, {12'd0, s.position_error});
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed blink trains; tidy keeps every pulse in tolerance and drops noise
    task automatic random_alarm_train(input int n, input int fixed_ch, input bit tidy);
        int unsigned ch;
        logic        lvl;
        logic [31:0] t;
        int          r;
        int          w;
        int          spread;
        for (int i = 0; i < n; i++)
        begin
            if (fixed_ch >= 0)
                ch = fixed_ch;
            else if ($urandom_range(0, 99) < 5)
                ch = $urandom_range(CHANNELS, 7);
            else
                ch = $urandom_range(0, CHANNELS - 1);
            r = tidy ? 99 : int'($urandom_range(0, 99));
            if (ch >= CHANNELS || r < 3)
            begin
                lvl = 1'($urandom_range(0, 1));
                t = $urandom;
            end
            else
            begin
                lvl = ($urandom_range(0, 99) < (tidy ? 100 : 75))
                      ? !line_state[ch].prev_level : line_state[ch].prev_level;
                spread = tidy ? int'(cfg_q.width_tolerance)
                              : 2 * int'(cfg_q.width_tolerance) + 2;
                if (r < 12)
                    t = line_state[ch].last_sample + $urandom_range(0, cfg_q.sample_interval);
                else if (line_state[ch].pulse_active && !lvl)
                begin
                    w = int'(cfg_q.expected_width) - spread
                        + int'($urandom_range(0, 2 * spread));
                    t = line_state[ch].pulse_start + ((w < 0) ? 32'd0 : 32'(w));
                end
                else
                    t = line_state[ch].last_sample + {16'd0, cfg_q.sample_interval}
                        + $urandom_range(0, 2 * cfg_q.expected_width + 1);
            end
            send_sample(ch[2:0], lvl, t, 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        alarm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result item with none expected, channel_out %0d",
                         $time, channel_out);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("channel_out", 32'(want.channel_out), 32'(channel_out));
                compare_field("accepted", 32'(want.accepted), 32'(accepted));
                compare_field("pulse_counted", 32'(want.pulse_counted), 32'(pulse_counted));
                compare_field("pulse_width_ms", want.pulse_width, pulse_width_ms);
                compare_field("window_closed", 32'(want.window_closed), 32'(window_closed));
                compare_field("pattern_class", 32'(want.pattern_class), 32'(pattern_class));
                compare_field("pattern_count", 32'(want.pattern_count), 32'(pattern_count));
                compare_field("channel_critical", 32'(want.channel_critical),
                              32'(channel_critical));
                compare_field("any_critical", 32'(want.any_critical), 32'(any_critical));
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_off = 1'b0;
                out_ready <= 1'b1;
            end
            else if (calm_left == 0 && $urandom_range(0, 99) < 30)
            begin
                out_ready <= 1'b0;
                repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40))
                    @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        cfg_q = CFG_DEFAULT;
        foreach (line_state[i])
            line_state[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_sample(DIRECTED[i].channel, DIRECTED[i].level, DIRECTED[i].now,
                        DIRECTED[i].typed, DIRECTED[i].want);

        load_settings(PHASE_CFG[0]);
        random_alarm_train(PHASE_ITEMS[0] / 3, -1, 1'b0);
        hold_off = 1'b1;
        random_alarm_train(PHASE_ITEMS[0] / 3, -1, 1'b0);
        wait_drained();
        random_alarm_train(PHASE_ITEMS[0] / 3, -1, 1'b0);

        for (int p = 1; p < 5; p++)
        begin
            load_settings(PHASE_CFG[p]);
            random_alarm_train(PHASE_ITEMS[p], -1, 1'b0);
        end

        load_settings(SATURATE_CFG);
        random_alarm_train(540, 3, 1'b1);
        send_sample(3'd3, 1'b0, line_state[3].last_sample + 32'd1000000, 1'b0, '0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### alarm_blink_pattern_monitor_top.f
+incdir+sv
sv/abpm_pkg.sv
sv/abpm_cfg_regs.sv
sv/abpm_chan_state.sv
sv/abpm_step_logic.sv
sv/alarm_blink_pattern_monitor_top.sv
sim/tb_alarm_blink_pattern_monitor_top.sv
